[sv/mlrt_pkg.sv]
// Package for the mip level reference count tracker.
// Holds the beat types, the result codes and the sequencer states; no dependencies.
package mlrt_pkg;

  localparam int unsigned CNT_W  = 16;
  localparam int unsigned SETC_W = 8;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [SETC_W-1:0] SETC_MAX = '1;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_LOAD = 2'd1,
    ACT_FREE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    PAL_NONE     = 2'd0,
    PAL_NEEDED   = 2'd1,
    PAL_RELEASED = 2'd2
  } palette_e;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_UNUSED    = 2'd1,
    ERR_SATURATED = 2'd2
  } error_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [5:0] set_index;
    logic [5:0] tile_index;
    logic [1:0] level;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]       out_level;
    action_e          action;
    palette_e         palette_event;
    logic [CNT_W-1:0] user_count;
    error_e           error;
    logic             last;
  } out_beat_t;

endpackage

[sv/mlrt_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the tracker's count stores; no dependencies.
module mlrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/mip_level_refcount_tracker.sv]
// Top level of the mip level reference count tracker.
// Depends on mlrt_pkg and mlrt_ram.
//
// Each accepted beat touches L = min(level, LEVELS-1) + 1 detail levels, highest first, and
// yields one result beat per level. After the accept, each level passes through a read state
// that reads the user count and set count memories and a modify state that modifies, writes
// back and loads the output register, waiting while that register is held. A beat whose set
// or tile is out of range is accepted and yields nothing. After reset a clearing pass over
// all SET_COUNT * TILES_PER_SET * LEVELS entries zeroes both memories; in_stall_o is high.
module mip_level_refcount_tracker
  import mlrt_pkg::*;
#(
  parameter int unsigned SET_COUNT     = 64,
  parameter int unsigned TILES_PER_SET = 64,
  parameter int unsigned LEVELS        = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int unsigned TOTAL = SET_COUNT * TILES_PER_SET * LEVELS;
  localparam int unsigned UA_W  = TOTAL > 1 ? $clog2(TOTAL) : 1;
  localparam int unsigned SET_W = SET_COUNT > 1 ? $clog2(SET_COUNT) : 1;

  state_e            state_q, state_d;
  logic [UA_W-1:0]   clr_q, clr_d;
  logic [UA_W-1:0]   base_q, base_d;
  logic [1:0]        lvl_q, lvl_d;
  op_e               op_q, op_d;
  logic [SET_W-1:0]  set_q, set_d;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q, out_d;

  logic              lvl_we, set_we, rd_en, advance;
  logic [UA_W-1:0]   lvl_waddr, lvl_raddr;
  logic [SET_W-1:0]  set_waddr;
  logic [CNT_W-1:0]  cnt_rd, cnt_new, lvl_wdata;
  logic [SETC_W-1:0] sc_rd, sc_new, set_wdata;
  out_beat_t         res;
  logic              in_range, accept;
  logic [1:0]        top;

  mlrt_ram #(.WIDTH(CNT_W), .DEPTH(TOTAL)) u_user_ram (
    .clk_i  (clk_i),
    .we_i   (lvl_we),
    .waddr_i(lvl_waddr),
    .wdata_i(lvl_wdata),
    .re_i   (rd_en),
    .raddr_i(lvl_raddr),
    .rdata_o(cnt_rd)
  );

  mlrt_ram #(.WIDTH(SETC_W), .DEPTH(SET_COUNT)) u_set_ram (
    .clk_i  (clk_i),
    .we_i   (set_we),
    .waddr_i(set_waddr),
    .wdata_i(set_wdata),
    .re_i   (rd_en),
    .raddr_i(set_q),
    .rdata_o(sc_rd)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign in_range    = (32'(in_data_i.set_index) < SET_COUNT) &&
                       (32'(in_data_i.tile_index) < TILES_PER_SET);
  assign top         = (32'(in_data_i.level) >= LEVELS) ? 2'(LEVELS - 1) : in_data_i.level;
  assign advance     = (state_q == ST_MODIFY) && (!out_valid_q || !out_stall_i);
  assign rd_en       = (state_q == ST_READ);
  assign lvl_raddr   = base_q + UA_W'(lvl_q);

  always_comb begin
    cnt_new = cnt_rd;
    sc_new  = sc_rd;
    res     = '{out_level: lvl_q, action: ACT_NONE, palette_event: PAL_NONE,
                user_count: '0, error: ERR_OK, last: (lvl_q == 2'd0)};
    if (op_q == OP_REQUEST) begin
      if (cnt_rd == CNT_MAX) begin
        res.error = ERR_SATURATED;
      end else begin
        if (cnt_rd == '0) begin
          res.action = ACT_LOAD;
          if (sc_rd == SETC_MAX) begin
            res.error = ERR_SATURATED;
          end else begin
            if (sc_rd == '0) begin
              res.palette_event = PAL_NEEDED;
            end
            sc_new = sc_rd + SETC_W'(1);
          end
        end
        cnt_new = cnt_rd + CNT_W'(1);
      end
    end else begin
      if (cnt_rd == '0) begin
        res.error = ERR_UNUSED;
      end else begin
        cnt_new = cnt_rd - CNT_W'(1);
        if (cnt_rd == CNT_W'(1)) begin
          res.action = ACT_FREE;
          if (sc_rd != '0) begin
            sc_new = sc_rd - SETC_W'(1);
            if (sc_rd == SETC_W'(1)) begin
              res.palette_event = PAL_RELEASED;
            end
          end
        end
      end
    end
    res.user_count = cnt_new;
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      lvl_we    = 1'b1;
      lvl_waddr = clr_q;
      lvl_wdata = '0;
      set_we    = (32'(clr_q) < SET_COUNT);
      set_waddr = SET_W'(clr_q);
      set_wdata = '0;
    end else begin
      lvl_we    = advance;
      lvl_waddr = lvl_raddr;
      lvl_wdata = cnt_new;
      set_we    = advance;
      set_waddr = set_q;
      set_wdata = sc_new;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    base_d      = base_q;
    lvl_d       = lvl_q;
    op_d        = op_q;
    set_d       = set_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + UA_W'(1);
        if (clr_q == UA_W'(TOTAL - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && in_range) begin
          op_d    = in_data_i.op;
          set_d   = SET_W'(in_data_i.set_index);
          lvl_d   = top;
          base_d  = (UA_W'(in_data_i.set_index) * UA_W'(TILES_PER_SET) +
                     UA_W'(in_data_i.tile_index)) * UA_W'(LEVELS);
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (advance) begin
          out_d       = res;
          out_valid_d = 1'b1;
          if (lvl_q == 2'd0) begin
            state_d = ST_IDLE;
          end else begin
            lvl_d   = lvl_q - 2'd1;
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    lvl_q  <= lvl_d;
    op_q   <= op_d;
    set_q  <= set_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> in_stall_o)
    else $error("Input taken during the clearing pass.");

  a_no_write_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MODIFY && out_valid_q && out_stall_i) |-> !lvl_we && !set_we)
    else $error("Count written back while the output register was held.");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && lvl_q == 2'd0) |=> (state_q == ST_IDLE) && out_valid_o && out_data_o.last)
    else $error("Final level did not end the item.");

  a_unused_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.error == ERR_UNUSED) |-> (res.action == ACT_NONE &&
      res.palette_event == PAL_NONE && cnt_new == cnt_rd))
    else $error("Release of an unused level changed state.");

endmodule
